FILE: sv/weighted_row_partition_assert.svh
// ----------------------------------------------------------------------------
// Weighted row partition assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ROW_PARTITION_ASSERT_SVH
`define WEIGHTED_ROW_PARTITION_ASSERT_SVH

// same-cycle implication
`define WRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("weighted_row_partition: same-cycle check failed");

// next-cycle implication
`define WRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("weighted_row_partition: next-cycle check failed");

`endif

FILE: sv/wrp_pkg.sv
// ----------------------------------------------------------------------------
// Weighted row partition package
// Field widths, register indexes and saturating arithmetic.
// ----------------------------------------------------------------------------
package wrp_pkg;

  localparam int unsigned WGT_W   = 48;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IW  = 3;

  typedef logic [WGT_W-1:0] wgt_t;
  typedef logic [CFG_IW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_NUM_ROWS  = 3'd0;
  localparam cfg_idx_t CFG_NUM_PARTS = 3'd1;
  localparam cfg_idx_t CFG_MY_PART   = 3'd2;
  localparam cfg_idx_t CFG_SIZE_X    = 3'd3;
  localparam cfg_idx_t CFG_SIZE_Z    = 3'd4;

  localparam wgt_t W48_MAX = {WGT_W{1'b1}};

  function automatic wgt_t sat_add48(input wgt_t a, input wgt_t b);
    logic [WGT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WGT_W] ? W48_MAX : s[WGT_W-1:0];
  endfunction

endpackage

FILE: sv/weighted_row_partition.sv
// ----------------------------------------------------------------------------
// Weighted row partition
// Accumulates per-row weights, then splits the rows greedily into contiguous
// blocks and reports the ghosted local extent of one selected part.
// ----------------------------------------------------------------------------
// Usage:
//   Items go in on start with row_index_i, weight_i, last_item_i; an item is
//   taken when start is high and busy is low. Each item is a read-modify-write
//   of the row store, busy held meanwhile. The item with last_item_i set
//   also runs the partition and the result comes out on done_o for one cycle.
//   A last item is written, then the weights of all rows in use are summed,
//   then the walk runs: each part starts with a setup step, and each row
//   examined is read, multiplied and compared, with one more read for a part
//   that runs through the last row (single store read port feeding one
//   multiply and one compare). done_o pulses the cycle after the walk ends,
//   as the block starts clearing the store, busy held.
//   After reset the same clearing pass runs before the first item is taken;
//   configuration writes take effect at once, so make them while busy is low.
//   The receiver cannot stall: it must treat the result as valid only in the
//   done_o cycle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module weighted_row_partition #(
  parameter int unsigned MAX_ROWS  = 1024,
  parameter int unsigned MAX_PARTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  wrp_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [wrp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [9:0]                    row_index_i,
  input  logic [31:0]                   weight_i,
  input  logic                          last_item_i,
  output logic                          done_o,
  output logic [12:0]                   cells_x_o,
  output logic [10:0]                   cells_y_o,
  output logic [12:0]                   cells_z_o,
  output logic [10:0]                   first_row_o,
  output logic signed [10:0]            final_row_o
);

  localparam int unsigned AW  = $clog2(MAX_ROWS);
  localparam int unsigned RW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW  = $clog2(MAX_PARTS + 1);
  localparam int unsigned OPW = wrp_pkg::WGT_W + 2;
  localparam int unsigned PRW = OPW + PW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC_WR, ST_SUM, ST_PART, ST_WALK_RD, ST_WALK_MUL, ST_WALK_CMP, ST_CLEAR
  } state_e;

  state_e state_q;

  logic [10:0] num_rows_q;
  logic [6:0]  num_parts_q;
  logic [5:0]  my_part_q;
  logic [12:0] size_x_q;
  logic [12:0] size_z_q;

  logic [AW-1:0]      row_q;
  logic               row_ok_q;
  logic [31:0]        w_q;
  logic               last_q;
  logic [RW-1:0]      sum_ptr_q;
  logic               sum_rd_q;
  wrp_pkg::wgt_t      total_q;
  logic [RW-1:0]      cur_q;
  logic [RW-1:0]      start_row_q;
  logic [PW-1:0]      cc_q;
  wrp_pkg::wgt_t      run_q;
  wrp_pkg::wgt_t      rw_q;
  logic [PRW-1:0]     prod_q;
  logic [AW-1:0]      clr_ptr_q;

  logic               done_q;
  logic [12:0]        cells_x_q;
  logic [10:0]        cells_y_q;
  logic [12:0]        cells_z_q;
  logic [10:0]        first_row_q;
  logic [10:0]        final_row_q;

  wrp_pkg::wgt_t      mem_q [MAX_ROWS];
  wrp_pkg::wgt_t      rdata_q;
  logic [AW-1:0]      raddr;
  logic               mem_we;
  logic [AW-1:0]      waddr;
  wrp_pkg::wgt_t      wdata;

  logic [RW-1:0]      nr;
  logic [PW-1:0]      np;
  logic [PW-1:0]      mp;
  logic               accept;
  logic               part_end;
  logic               finish;
  logic [RW-1:0]      res_first;
  logic [RW-1:0]      res_end;
  logic [OPW-1:0]     mul_opnd;
  logic [PRW-1:0]     tot2;

  // effective configuration
  always_comb begin
    logic [31:0] nr32;
    logic [31:0] np32;
    logic [31:0] mp32;
    nr32 = 32'(num_rows_q);
    if (nr32 == 32'd0) nr32 = 32'd1;
    if (nr32 > 32'(MAX_ROWS)) nr32 = 32'(MAX_ROWS);
    np32 = 32'(num_parts_q);
    if (np32 == 32'd0) np32 = 32'd1;
    if (np32 > 32'(MAX_PARTS)) np32 = 32'(MAX_PARTS);
    mp32 = 32'(my_part_q);
    if (mp32 > np32 - 32'd1) mp32 = np32 - 32'd1;
    nr = RW'(nr32);
    np = PW'(np32);
    mp = PW'(mp32);
  end

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign tot2     = PRW'({total_q, 1'b0});
  assign mul_opnd = OPW'({run_q, 1'b0}) + OPW'(rdata_q);
  assign part_end = ((state_q == ST_WALK_RD) && (cur_q == nr)) ||
                    ((state_q == ST_WALK_CMP) && (prod_q >= tot2));
  assign finish   = ((state_q == ST_PART) && (cc_q == np - PW'(1))) ||
                    (part_end && (cc_q == mp));
  assign res_first = (state_q == ST_PART) ? cur_q : start_row_q;
  assign res_end   = (state_q == ST_PART) ? nr : cur_q;

  // store port selection
  always_comb begin
    unique case (state_q)
      ST_IDLE: raddr = AW'(row_index_i);
      ST_SUM:  raddr = sum_ptr_q[AW-1:0];
      default: raddr = cur_q[AW-1:0];
    endcase
    mem_we = ((state_q == ST_ACC_WR) && row_ok_q) || (state_q == ST_CLEAR);
    waddr  = (state_q == ST_CLEAR) ? clr_ptr_q : row_q;
    wdata  = (state_q == ST_CLEAR) ? '0 :
             wrp_pkg::sat_add48(rdata_q, wrp_pkg::WGT_W'(w_q));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q  <= 11'd1024;
      num_parts_q <= 7'd1;
      my_part_q   <= 6'd0;
      size_x_q    <= 13'd1;
      size_z_q    <= 13'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wrp_pkg::CFG_NUM_ROWS:  num_rows_q  <= cfg_data_i[10:0];
        wrp_pkg::CFG_NUM_PARTS: num_parts_q <= cfg_data_i[6:0];
        wrp_pkg::CFG_MY_PART:   my_part_q   <= cfg_data_i[5:0];
        wrp_pkg::CFG_SIZE_X:    size_x_q    <= cfg_data_i;
        wrp_pkg::CFG_SIZE_Z:    size_z_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_ptr_q <= '0;
      done_q    <= 1'b0;
      sum_rd_q  <= 1'b0;
    end else begin
      done_q <= finish;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            row_q    <= AW'(row_index_i);
            row_ok_q <= (32'(row_index_i) < 32'(MAX_ROWS));
            w_q      <= weight_i;
            last_q   <= last_item_i;
            state_q  <= ST_ACC_WR;
          end
        end
        ST_ACC_WR: begin
          sum_ptr_q <= '0;
          sum_rd_q  <= 1'b0;
          total_q   <= '0;
          state_q   <= last_q ? ST_SUM : ST_IDLE;
        end
        ST_SUM: begin
          if (sum_rd_q) begin
            total_q <= wrp_pkg::sat_add48(total_q, rdata_q);
          end
          if (sum_ptr_q != nr) begin
            sum_ptr_q <= sum_ptr_q + RW'(1);
            sum_rd_q  <= 1'b1;
          end else begin
            sum_rd_q <= 1'b0;
            if (!sum_rd_q) begin
              cur_q   <= '0;
              cc_q    <= '0;
              state_q <= ST_PART;
            end
          end
        end
        ST_PART: begin
          start_row_q <= cur_q;
          run_q       <= '0;
          if (!finish) begin
            state_q <= ST_WALK_RD;
          end
        end
        ST_WALK_RD: begin
          if (!part_end) begin
            state_q <= ST_WALK_MUL;
          end
        end
        ST_WALK_MUL: begin
          prod_q  <= PRW'(np) * PRW'(mul_opnd);
          rw_q    <= rdata_q;
          state_q <= ST_WALK_CMP;
        end
        ST_WALK_CMP: begin
          if (!part_end) begin
            run_q   <= run_q + rw_q;
            cur_q   <= cur_q + RW'(1);
            state_q <= ST_WALK_RD;
          end
        end
        ST_CLEAR: begin
          if (clr_ptr_q == AW'(MAX_ROWS - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_ptr_q <= clr_ptr_q + AW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (part_end && !finish) begin
        cc_q    <= cc_q + PW'(1);
        state_q <= ST_PART;
      end

      if (finish) begin
        cells_x_q   <= size_x_q + 13'd2;
        cells_z_q   <= size_z_q + 13'd2;
        cells_y_q   <= 11'(32'(res_end) - 32'(res_first) + 32'd2);
        first_row_q <= 11'(res_first);
        final_row_q <= 11'(32'(res_end) - 32'd1);
        clr_ptr_q   <= '0;
        state_q     <= ST_CLEAR;
      end
    end
  end

  assign done_o      = done_q;
  assign cells_x_o   = cells_x_q;
  assign cells_y_o   = cells_y_q;
  assign cells_z_o   = cells_z_q;
  assign first_row_o = first_row_q;
  assign final_row_o = final_row_q;

`include "weighted_row_partition_assert.svh"

  `WRP_ASSERT_NOW(a_done_in_clear, done_q, state_q == ST_CLEAR)
  `WRP_ASSERT_NEXT(a_done_single, done_q, !done_q)
  `WRP_ASSERT_NEXT(a_item_no_result, accept, !done_q && busy)
  `WRP_ASSERT_NOW(a_walk_in_range, state_q == ST_WALK_MUL, cur_q < nr)

endmodule

FILE: tb/weighted_row_partition_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted row partition testbench
// Sends batches of row weights through the command port and keeps its own
// model of the row store and the greedy partition. Every reported extent is
// checked field by field against the oldest prediction. Configuration is
// rewritten between phases, including out-of-range and wrapping values.
// ----------------------------------------------------------------------------
module weighted_row_partition_test;

  localparam int unsigned ROW_SLOTS  = 1024;
  localparam int unsigned PART_SLOTS = 64;
  localparam int unsigned ITEM_BUDGET = 480;

  typedef longint unsigned u64_t;

  localparam u64_t WGT_CAP = {16'd0, wrp_pkg::W48_MAX};

  typedef struct packed {
    logic [12:0] cells_x;
    logic [10:0] cells_y;
    logic [12:0] cells_z;
    logic [10:0] first_row;
    logic [10:0] final_row;
  } extent_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  wrp_pkg::cfg_idx_t          cfg_idx_i   = wrp_pkg::CFG_NUM_ROWS;
  logic [wrp_pkg::CFG_W-1:0]  cfg_data_i  = '0;
  logic                       start       = 1'b0;
  logic                       busy;
  logic [9:0]                 row_index_i = '0;
  logic [31:0]                weight_i    = '0;
  logic                       last_item_i = 1'b0;
  logic                       done_o;
  logic [12:0]                cells_x_o;
  logic [10:0]                cells_y_o;
  logic [12:0]                cells_z_o;
  logic [10:0]                first_row_o;
  logic signed [10:0]         final_row_o;

  // model state
  u64_t        row_wgt [ROW_SLOTS];
  logic [10:0] cfg_rows;
  logic [6:0]  cfg_parts;
  logic [5:0]  cfg_sel;
  logic [12:0] cfg_sx;
  logic [12:0] cfg_sz;

  extent_t     expected_extents [$];
  int unsigned fail_count = 0;
  logic        steady_run = 1'b0;

  weighted_row_partition #(
    .MAX_ROWS  (ROW_SLOTS),
    .MAX_PARTS (PART_SLOTS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .busy        (busy),
    .row_index_i (row_index_i),
    .weight_i    (weight_i),
    .last_item_i (last_item_i),
    .done_o      (done_o),
    .cells_x_o   (cells_x_o),
    .cells_y_o   (cells_y_o),
    .cells_z_o   (cells_z_o),
    .first_row_o (first_row_o),
    .final_row_o (final_row_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic u64_t add_capped(input u64_t a, input u64_t b);
    u64_t s;
    s = a + b;
    return (s > WGT_CAP) ? WGT_CAP : s;
  endfunction

  function automatic void clear_store();
    foreach (row_wgt[i]) row_wgt[i] = 0;
  endfunction

  function automatic u64_t rows_in_use();
    u64_t n;
    n = u64_t'(cfg_rows);
    if (n == 0) n = 1;
    if (n > u64_t'(ROW_SLOTS)) n = u64_t'(ROW_SLOTS);
    return n;
  endfunction

  function automatic u64_t parts_from(input logic [6:0] p);
    u64_t n;
    n = u64_t'(p);
    if (n == 0) n = 1;
    if (n > u64_t'(PART_SLOTS)) n = u64_t'(PART_SLOTS);
    return n;
  endfunction

  // accumulate one item; on the last item walk the partition
  function automatic void predict_item(input logic [9:0] row, input logic [31:0] w,
                                       input logic last);
    u64_t    nr, np, sel, total, cur, run, first, stop, block_start;
    u64_t    part;
    logic    found;
    extent_t ext;
    row_wgt[row] = add_capped(row_wgt[row], u64_t'(w));
    if (!last) return;
    nr = rows_in_use();
    np = parts_from(cfg_parts);
    sel = u64_t'(cfg_sel);
    if (sel > np - 1) sel = np - 1;
    total = 0;
    for (u64_t r = 0; r < nr; r++) total = add_capped(total, row_wgt[r]);
    cur = 0;
    first = 0;
    stop = nr;
    found = 1'b0;
    for (part = 0; part + 1 < np && !found; part++) begin
      block_start = cur;
      run = 0;
      while (cur < nr && 64'd2 * np * run + np * row_wgt[cur] < 64'd2 * total) begin
        run += row_wgt[cur];
        cur++;
      end
      if (part == sel) begin
        first = block_start;
        stop = cur;
        found = 1'b1;
      end
    end
    if (sel == np - 1) begin
      first = cur;
      stop = nr;
    end
    ext.cells_x   = cfg_sx + 13'd2;
    ext.cells_y   = 11'(stop - first + 2);
    ext.cells_z   = cfg_sz + 13'd2;
    ext.first_row = 11'(first);
    ext.final_row = 11'(stop - 1);
    expected_extents.push_back(ext);
    clear_store();
  endfunction

  function automatic void check_field(input string name, input logic signed [13:0] want,
                                      input logic signed [13:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_extent
    extent_t want;
    if (rst_ni && done_o) begin
      if (expected_extents.size() == 0) begin
        $error("extent reported with none expected");
        fail_count++;
      end else begin
        want = expected_extents.pop_front();
        check_field("cells_x", 14'(want.cells_x), 14'(cells_x_o));
        check_field("cells_y", 14'(want.cells_y), 14'(cells_y_o));
        check_field("cells_z", 14'(want.cells_z), 14'(cells_z_o));
        check_field("first_row", 14'(want.first_row), 14'(first_row_o));
        check_field("final_row", 14'($signed(want.final_row)), 14'(final_row_o));
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_run) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 6);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input logic [9:0] row, input logic [31:0] w, input logic last,
                           input int unsigned gap);
    start       <= 1'b1;
    row_index_i <= row;
    weight_i    <= w;
    last_item_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_item(row, w, last);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // hold the sender until all extents are in and the block is idle
  task automatic settle();
    start <= 1'b0;
    @(negedge clk_i);
    while (expected_extents.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [wrp_pkg::CFG_W-1:0] rows,
                              input logic [wrp_pkg::CFG_W-1:0] parts,
                              input logic [wrp_pkg::CFG_W-1:0] sel,
                              input logic [wrp_pkg::CFG_W-1:0] sx,
                              input logic [wrp_pkg::CFG_W-1:0] sz);
    logic [wrp_pkg::CFG_W-1:0] data [5];
    wrp_pkg::cfg_idx_t         idx [5];
    int                        k;
    data = '{rows, parts, sel, sx, sz};
    idx  = '{wrp_pkg::CFG_NUM_ROWS, wrp_pkg::CFG_NUM_PARTS, wrp_pkg::CFG_MY_PART,
             wrp_pkg::CFG_SIZE_X, wrp_pkg::CFG_SIZE_Z};
    for (k = 0; k < 5; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= data[k];
      case (idx[k])
        wrp_pkg::CFG_NUM_ROWS:  cfg_rows  = data[k][10:0];
        wrp_pkg::CFG_NUM_PARTS: cfg_parts = data[k][6:0];
        wrp_pkg::CFG_MY_PART:   cfg_sel   = data[k][5:0];
        wrp_pkg::CFG_SIZE_X:    cfg_sx    = data[k];
        wrp_pkg::CFG_SIZE_Z:    cfg_sz    = data[k];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_batch(input int unsigned len);
    int unsigned mode, k;
    logic [31:0] base, w;
    logic [9:0]  row;
    u64_t        nr;
    nr = rows_in_use();
    mode = $urandom_range(5);
    base = $urandom();
    for (k = 0; k < len; k++) begin
      if ($urandom_range(9) < 7) row = 10'($urandom_range(32'(nr - 1)));
      else row = 10'($urandom());
      case (mode)
        0: w = base;
        1: w = $urandom();
        2: w = $urandom_range(15);
        3: w = '0;
        4: w = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom();
        default: w = base >> $urandom_range(31);
      endcase
      send_item(row, w, k == len - 1, pick_gap());
    end
  endtask

  task automatic test_reset_values();
    send_item(10'd1023, 32'hFFFF_FFFF, 1'b0, 0);
    send_item(10'd0, 32'd0, 1'b1, 2);
    settle();
  endtask

  task automatic test_field_extremes();
    write_config(13'd1024, 13'd4, 13'd3, 13'd4096, 13'd4096);
    send_item(10'd0, 32'hFFFF_FFFF, 1'b0, 0);
    send_item(10'd1023, 32'hFFFF_FFFF, 1'b0, 1);
    send_item(10'd511, 32'h5555_5555, 1'b0, 0);
    send_item(10'd512, 32'hAAAA_AAAA, 1'b1, 0);
    settle();
  endtask

  task automatic test_zero_total();
    write_config(13'd100, 13'd8, 13'd2, 13'd5, 13'd6);
    send_item(10'd3, 32'd0, 1'b0, 0);
    send_item(10'd50, 32'd0, 1'b1, 0);
    settle();
    // selected part beyond the part count
    write_config(13'd100, 13'd8, 13'd63, 13'd5, 13'd6);
    send_item(10'd7, 32'd0, 1'b1, 0);
    settle();
  endtask

  // three unit rows, five parts: the walk runs off the end before the last part
  task automatic test_walk_end();
    write_config(13'd3, 13'd5, 13'd3, 13'd7, 13'd9);
    send_item(10'd0, 32'd1, 1'b0, 0);
    send_item(10'd1, 32'd1, 1'b0, 0);
    send_item(10'd2, 32'd1, 1'b1, 0);
    settle();
  endtask

  task automatic test_register_limits();
    write_config(13'd0, 13'd0, 13'd0, 13'd8191, 13'd0);
    send_item(10'd0, 32'd9, 1'b1, 0);
    settle();
    write_config(13'd2047, 13'd127, 13'd40, 13'd8190, 13'd8191);
    send_item(10'd700, 32'd12345, 1'b1, 0);
    settle();
    write_config(13'h1800, 13'h1FC0, 13'h1FFF, 13'h0AAA, 13'h1555);
    send_item(10'd0, 32'd1, 1'b1, 0);
    settle();
    write_config(13'd1025, 13'd65, 13'd64, 13'h1555, 13'h0AAA);
    send_item(10'h2AA, 32'hDEAD_BEEF, 1'b1, 0);
    settle();
  endtask

  // weight beyond num_rows is ignored, then must be gone in the next batch
  task automatic test_rows_beyond();
    write_config(13'd10, 13'd2, 13'd1, 13'd1, 13'd1);
    send_item(10'd900, 32'hFFFF_FFFF, 1'b0, 0);
    send_item(10'd5, 32'd3, 1'b0, 0);
    send_item(10'd1000, 32'd77, 1'b1, 0);
    settle();
    write_config(13'd1024, 13'd2, 13'd0, 13'd1, 13'd1);
    send_item(10'd0, 32'd1, 1'b1, 0);
    settle();
  endtask

  // full-scale weight stacked on one row, back to back, against a light row
  task automatic test_heavy_rows();
    int unsigned k;
    write_config(13'd2, 13'd2, 13'd1, 13'd1, 13'd1);
    steady_run = 1'b1;
    for (k = 0; k < 24; k++) send_item(10'd0, 32'hFFFF_FFFF, 1'b0, 0);
    send_item(10'd1, 32'd5, 1'b1, 0);
    steady_run = 1'b0;
    settle();
  endtask

  task automatic test_random_batches();
    int unsigned sent, batches, len, k;
    logic [wrp_pkg::CFG_W-1:0] rows, parts, sel, sx, sz;
    sent = 0;
    while (sent < ITEM_BUDGET) begin
      case ($urandom_range(9))
        0, 1, 2: rows = 13'($urandom_range(16, 1));
        3, 4:    rows = 13'($urandom_range(128, 17));
        5:       rows = 13'd1024;
        6:       rows = 13'($urandom_range(1024, 1));
        7:       rows = 13'd0;
        8:       rows = 13'($urandom_range(2047, 1025));
        default: rows = 13'($urandom_range(8191));
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: parts = 13'($urandom_range(8, 1));
        4:          parts = 13'($urandom_range(64, 9));
        5:          parts = 13'd64;
        6:          parts = 13'd1;
        7:          parts = 13'd0;
        8:          parts = 13'($urandom_range(127, 65));
        default:    parts = 13'($urandom_range(8191));
      endcase
      if ($urandom_range(9) < 7) begin
        sel = 13'($urandom_range(32'(parts_from(parts[6:0]) - 1)));
      end else begin
        sel = 13'($urandom_range(8191));
      end
      case ($urandom_range(4))
        0, 1:    sx = 13'($urandom_range(64, 1));
        2:       sx = 13'd4096;
        3:       sx = 13'd8191;
        default: sx = 13'($urandom_range(8191));
      endcase
      sz = ($urandom_range(1)) ? 13'($urandom_range(8191)) : 13'($urandom_range(4096, 1));
      write_config(rows, parts, sel, sx, sz);
      batches = $urandom_range(3, 1);
      steady_run = ($urandom_range(3) == 0);
      for (k = 0; k < batches; k++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
        send_batch(len);
        sent += len;
      end
      steady_run = 1'b0;
      settle();
    end
  endtask

  initial begin
    clear_store();
    cfg_rows  = 11'd1024;
    cfg_parts = 7'd1;
    cfg_sel   = '0;
    cfg_sx    = 13'd1;
    cfg_sz    = 13'd1;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_field_extremes();
    test_zero_total();
    test_walk_end();
    test_register_limits();
    test_rows_beyond();
    test_heavy_rows();
    test_random_batches();
    settle();
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/wrp_pkg.sv
sv/weighted_row_partition.sv
tb/weighted_row_partition_test.sv
